// ===== src/crc16_packet_deframer_core_assert.svh =====
// Assertion macros shared by the deframer checker.
`ifndef CRC16_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define CRC16_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cpd_pkg.sv =====
// Shared types, codes and the CRC-16/XMODEM byte update for the frame deframer.
package cpd_pkg;

   localparam logic [7:0]  START_BYTE        = 8'h02;
   localparam logic [7:0]  END_BYTE          = 8'h03;
   localparam logic [15:0] CRC_POLY          = 16'h1021;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd100;
   localparam logic [15:0] TICKS_MAX         = 16'hFFFF;

   // result event codes
   localparam logic [2:0] EV_DATA    = 3'd0;
   localparam logic [2:0] EV_GOOD    = 3'd1;
   localparam logic [2:0] EV_BAD_END = 3'd2;
   localparam logic [2:0] EV_BAD_CRC = 3'd3;
   localparam logic [2:0] EV_TIMEOUT = 3'd4;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  payload_byte;
      logic [7:0]  byte_index;
      logic [7:0]  payload_length;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
   } rsp_beat_type;

   // MSB-first, no reflection, one byte per call
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/crc16_packet_deframer_core.sv =====
// Length-prefixed frame receiver with CRC-16/XMODEM check (top level).
//
// Each req beat is either a received serial byte (req_kind 0) or one time
// tick (req_kind 1). The core hunts for start byte 0x02, takes a length
// byte, then passes every payload byte out at once as a data event with its
// index while folding it into a CRC-16/XMODEM (poly 0x1021, init 0). A
// big-endian CRC and an end byte follow; the end byte yields good, bad end
// byte (which wins over a CRC mismatch) or CRC mismatch. Ticks only count
// while a frame is open; once csr_wr_data's timeout_ticks is reached the
// frame is dropped with a timeout event. Bytes outside a frame other than
// the start byte are discarded. One req beat is taken every cycle unless
// req_stall is high: all work for a beat is the frame state update plus an
// eight-step CRC byte update, done in the cycle of acceptance, and the result
// (zero or one beat) is registered into a two-beat output queue feeding rsp.
// req_stall rises only while that queue holds two beats, so a rsp side that
// takes a beat every cycle never slows the input. timeout_ticks resets to 100;
// the user must write it via csr_wr_en only while the core is idle (not enforced).
module crc16_packet_deframer_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [7:0]  rsp_payload_length,
   output logic [15:0] rsp_received_crc,
   output logic [15:0] rsp_computed_crc,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import cpd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_DATA = 3'd2,
      PH_CRCH = 3'd3,
      PH_CRCL = 3'd4,
      PH_END  = 3'd5
   } phase_type;

   phase_type    phase_ff,   phase_in;
   logic [7:0]   length_ff,  length_in;
   logic [7:0]   count_ff,   count_in;
   logic [15:0]  crc_ff,     crc_in;
   logic [15:0]  rx_crc_ff,  rx_crc_in;
   logic [15:0]  ticks_ff,   ticks_in;
   logic [15:0]  timeout_ff;

   logic         accept;
   logic         frame_open;
   logic         emit;
   rsp_beat_type beat;
   rsp_beat_type rsp_beat;
   logic         queue_full;
   logic [15:0]  ticks_inc;
   logic [15:0]  crc_byte;
   logic [7:0]   count_inc;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~req_stall;

   assign frame_open = (phase_ff == PH_LEN)  || (phase_ff == PH_DATA) ||
                       (phase_ff == PH_CRCH) || (phase_ff == PH_CRCL) ||
                       (phase_ff == PH_END);
   assign ticks_inc  = (ticks_ff != TICKS_MAX) ? ticks_ff + 16'd1 : ticks_ff;
   assign crc_byte   = crc_add(crc_ff, req_rx_byte);
   assign count_inc  = count_ff + 8'd1;

   // Frame state update and result for the beat being accepted.
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      ticks_in  = ticks_ff;
      emit      = 1'b0;
      beat      = '{event_res:      EV_DATA,
                    payload_byte:   8'h00,
                    byte_index:     8'h00,
                    payload_length: length_ff,
                    received_crc:   rx_crc_ff,
                    computed_crc:   crc_ff};

      if (req_kind) begin
         // tick: counts only inside an open frame, saturating
         if (frame_open) begin
            ticks_in = ticks_inc;
            if (ticks_inc >= timeout_ff) begin
               phase_in       = PH_HUNT;
               ticks_in       = 16'd0;
               emit           = 1'b1;
               beat.event_res = EV_TIMEOUT;
            end
         end
      end else begin
         case (phase_ff)
            PH_LEN: begin
               length_in = req_rx_byte;
               phase_in  = (req_rx_byte == 8'd0) ? PH_CRCH : PH_DATA;
            end
            PH_DATA: begin
               crc_in   = crc_byte;
               count_in = count_inc;
               if (count_inc == length_ff) begin
                  phase_in = PH_CRCH;
               end
               emit              = 1'b1;
               beat.payload_byte = req_rx_byte;
               beat.byte_index   = count_ff;
               beat.received_crc = 16'd0;
               beat.computed_crc = crc_byte;
            end
            PH_CRCH: begin
               rx_crc_in = {req_rx_byte, 8'h00};
               phase_in  = PH_CRCL;
            end
            PH_CRCL: begin
               rx_crc_in = {rx_crc_ff[15:8], req_rx_byte};
               phase_in  = PH_END;
            end
            PH_END: begin
               emit     = 1'b1;
               phase_in = PH_HUNT;
               ticks_in = 16'd0;
               if (req_rx_byte != END_BYTE) begin
                  beat.event_res = EV_BAD_END;
               end else if (rx_crc_ff == crc_ff) begin
                  beat.event_res = EV_GOOD;
               end else begin
                  beat.event_res = EV_BAD_CRC;
               end
            end
            default: begin
               // hunting, and unused phase codes
               if (req_rx_byte == START_BYTE) begin
                  phase_in  = PH_LEN;
                  length_in = 8'd0;
                  count_in  = 8'd0;
                  crc_in    = 16'd0;
                  rx_crc_in = 16'd0;
                  ticks_in  = 16'd0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         length_ff  <= 8'd0;
         count_ff   <= 8'd0;
         crc_ff     <= 16'd0;
         rx_crc_ff  <= 16'd0;
         ticks_ff   <= 16'd0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            length_ff <= length_in;
            count_ff  <= count_in;
            crc_ff    <= crc_in;
            rx_crc_ff <= rx_crc_in;
            ticks_ff  <= ticks_in;
         end
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   cpd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept & emit),
      .push_beat (beat),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat),
      .rsp_stall (rsp_stall)
   );

   assign rsp_event_res      = rsp_beat.event_res;
   assign rsp_payload_byte   = rsp_beat.payload_byte;
   assign rsp_byte_index     = rsp_beat.byte_index;
   assign rsp_payload_length = rsp_beat.payload_length;
   assign rsp_received_crc   = rsp_beat.received_crc;
   assign rsp_computed_crc   = rsp_beat.computed_crc;

endmodule

// ===== src/cpd_rsp_queue.sv =====
// Two-beat result queue between the frame logic and the rsp channel.
module cpd_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cpd_pkg::rsp_beat_type push_beat,
   output logic                  full,
   output logic                  rsp_valid,
   output cpd_pkg::rsp_beat_type rsp_beat,
   input  logic                  rsp_stall
);
   import cpd_pkg::*;

   rsp_beat_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_beat  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

// ===== src/cpd_checker.sv =====
// Port-level checks for the deframer core, bound to the top level.
`include "crc16_packet_deframer_core_assert.svh"

module cpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [7:0]  rsp_payload_byte,
   input logic [7:0]  rsp_byte_index,
   input logic [7:0]  rsp_payload_length,
   input logic [15:0] rsp_received_crc
);
   import cpd_pkg::*;

   `CPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped while stalled")
   `CPD_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_event_res) && $stable(rsp_payload_byte) && $stable(rsp_received_crc), "stalled rsp beat changed")
   `CPD_ASSERT_NOW(a_index_in_frame, rsp_valid && rsp_event_res == EV_DATA, rsp_byte_index < rsp_payload_length, "data index beyond frame length")
   `CPD_ASSERT_NOW(a_end_clean, rsp_valid && rsp_event_res != EV_DATA, rsp_payload_byte == 8'h00 && rsp_byte_index == 8'h00 && rsp_event_res <= EV_TIMEOUT, "bad frame-end beat")

endmodule

bind crc16_packet_deframer_core cpd_checker u_cpd_checker (.*);

// ===== sim/crc16_packet_deframer_core_tb.sv =====
// Self-checking testbench for the CRC-16 packet deframer core.
`timescale 1ns / 1ps

class deframer_scoreboard;
   typedef enum logic [2:0] {
      ST_HUNT, ST_LEN, ST_DATA, ST_CRC_HI, ST_CRC_LO, ST_END
   } rx_phase_type;

   rx_phase_type phase;
   logic [15:0] timeout_ticks;
   logic [7:0]  frame_len;
   logic [7:0]  data_count;
   logic [15:0] crc_acc;
   logic [15:0] crc_rx;
   logic [15:0] tick_count;
   cpd_pkg::rsp_beat_type expected_q[$];
   int errors;
   int checked;

   function new();
      phase         = ST_HUNT;
      timeout_ticks = cpd_pkg::TIMEOUT_RESET;
      frame_len     = '0;
      data_count    = '0;
      crc_acc       = '0;
      crc_rx        = '0;
      tick_count    = '0;
      errors        = 0;
      checked       = 0;
   endfunction

   // bit-serial CRC-16/XMODEM, data MSB first
   static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[15] ^ d[i];
         crc = {crc[14:0], 1'b0};
         if (fb) begin
            crc = crc ^ cpd_pkg::CRC_POLY;
         end
      end
      return crc;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void push_event(logic [2:0] code, logic [7:0] pb, logic [7:0] idx,
                            logic [15:0] rcrc);
      cpd_pkg::rsp_beat_type ev;
      ev.event_res      = code;
      ev.payload_byte   = pb;
      ev.byte_index     = idx;
      ev.payload_length = frame_len;
      ev.received_crc   = rcrc;
      ev.computed_crc   = crc_acc;
      expected_q.push_back(ev);
   endfunction

   // accepted input beat: kind 1 is a tick, kind 0 a received byte
   function void note_beat(logic kind, logic [7:0] b);
      logic [7:0] idx;
      logic [2:0] code;
      if (kind) begin
         if (phase != ST_HUNT) begin
            if (tick_count != cpd_pkg::TICKS_MAX) begin
               tick_count++;
            end
            if (tick_count >= timeout_ticks) begin
               phase      = ST_HUNT;
               tick_count = '0;
               push_event(cpd_pkg::EV_TIMEOUT, 8'h00, 8'h00, crc_rx);
            end
         end
         return;
      end
      case (phase)
         ST_LEN: begin
            frame_len = b;
            phase     = (b == 8'h00) ? ST_CRC_HI : ST_DATA;
         end
         ST_DATA: begin
            idx     = data_count;
            crc_acc = crc_step(crc_acc, b);
            data_count++;
            if (data_count == frame_len) begin
               phase = ST_CRC_HI;
            end
            push_event(cpd_pkg::EV_DATA, b, idx, 16'h0000);
         end
         ST_CRC_HI: begin
            crc_rx = {b, 8'h00};
            phase  = ST_CRC_LO;
         end
         ST_CRC_LO: begin
            crc_rx[7:0] = b;
            phase       = ST_END;
         end
         ST_END: begin
            if (b != cpd_pkg::END_BYTE) begin
               code = cpd_pkg::EV_BAD_END;
            end else if (crc_rx == crc_acc) begin
               code = cpd_pkg::EV_GOOD;
            end else begin
               code = cpd_pkg::EV_BAD_CRC;
            end
            phase      = ST_HUNT;
            tick_count = '0;
            push_event(code, 8'h00, 8'h00, crc_rx);
         end
         default: begin
            if (b == cpd_pkg::START_BYTE) begin
               phase      = ST_LEN;
               frame_len  = '0;
               data_count = '0;
               crc_acc    = '0;
               crc_rx     = '0;
               tick_count = '0;
            end
         end
      endcase
   endfunction

   task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         report($sformatf("result %0d: %s is 0x%0h, want 0x%0h", checked, name, got, want));
      end
   endtask

   task check_rsp(cpd_pkg::rsp_beat_type got);
      cpd_pkg::rsp_beat_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("result beat with nothing expected, event %0d", got.event_res));
         return;
      end
      want = expected_q.pop_front();
      compare_field("event_res", 16'(got.event_res), 16'(want.event_res));
      compare_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      compare_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
      compare_field("payload_length", 16'(got.payload_length), 16'(want.payload_length));
      compare_field("received_crc", got.received_crc, want.received_crc);
      compare_field("computed_crc", got.computed_crc, want.computed_crc);
      checked++;
   endtask
endclass

module crc16_packet_deframer_core_tb;
   import cpd_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 6;
   // results come out of a registered queue; leave slack before csr writes
   localparam int SETTLE_CYCLES = 4;
   // hang limit for the whole run, in ns
   localparam int LIMIT_NS      = 36_000_000;
   localparam int PHASE_ITEMS   = 210;
   // truncated frames are closed by timeout ticks, only when that is cheap
   localparam int CUT_TICKS_MAX = 300;

   // frame flaws for the generator
   localparam int FLAW_NONE = 0;
   localparam int FLAW_END  = 1;
   localparam int FLAW_CRC  = 2;
   localparam int FLAW_CUT  = 3;

   // result-side stall patterns
   localparam int STALL_NEVER  = 0;
   localparam int STALL_LIGHT  = 1;
   localparam int STALL_TOGGLE = 2;
   localparam int STALL_HEAVY  = 3;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_byte_index;
   logic [7:0]  rsp_payload_length;
   logic [15:0] rsp_received_crc;
   logic [15:0] rsp_computed_crc;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   deframer_scoreboard sb;
   req_item_type       stim_q[$];
   int                 cur_timeout = int'(TIMEOUT_RESET);

   crc16_packet_deframer_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_length (rsp_payload_length),
      .rsp_received_crc   (rsp_received_crc),
      .rsp_computed_crc   (rsp_computed_crc),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------
   // Stimulus building. Everything lands in stim_q and is played out
   // later by the beat driver, so generation never touches the bus.
   // ---------------------------------------------------------------

   function automatic void push_beat(logic kind, logic [7:0] b);
      stim_q.push_back({kind, b});
   endfunction

   // rx_byte is don't-care on ticks, so randomize it (may even be 0x02)
   function automatic void push_tick();
      push_beat(KIND_TICK, 8'($urandom_range(0, 255)));
   endfunction

   // start byte, then length, payload, CRC hi/lo and end byte; only the
   // first 'keep' of those follow the start byte. Up to 'budget' ticks are
   // sprinkled in, which keeps the frame alive when budget < timeout.
   function automatic int put_frame(input logic [7:0] pl[$], input logic [15:0] crc_flip,
                                    input logic [7:0] end_b, input int keep,
                                    input int budget);
      logic [7:0]  body[$];
      logic [15:0] crc;
      int          n;
      crc = '0;
      foreach (pl[i]) begin
         crc = sb.crc_step(crc, pl[i]);
      end
      crc = crc ^ crc_flip;
      body.push_back(8'(pl.size()));
      foreach (pl[i]) begin
         body.push_back(pl[i]);
      end
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      body.push_back(end_b);
      push_beat(KIND_BYTE, START_BYTE);
      n = 1;
      for (int i = 0; i < keep && i < body.size(); i++) begin
         if (budget > 0 && $urandom_range(0, 5) == 0) begin
            push_tick();
            budget--;
            n++;
         end
         push_beat(KIND_BYTE, body[i]);
         n++;
      end
      return n;
   endfunction

   // One random frame. Mostly short payloads; rarely a near-full one.
   function automatic int gen_frame(int flaw);
      logic [7:0]  pl[$];
      logic [15:0] flip;
      logic [7:0]  end_b;
      int          r;
      int          len;
      int          keep;
      int          n;
      r = $urandom_range(0, 99);
      if (r < 1) begin
         len = $urandom_range(200, 255);
      end else if (r < 12) begin
         len = $urandom_range(13, 64);
      end else begin
         len = $urandom_range(0, 12);
      end
      repeat (len) pl.push_back(8'($urandom_range(0, 255)));
      flip  = 16'h0000;
      end_b = END_BYTE;
      keep  = len + 4;
      case (flaw)
         FLAW_CRC: flip = 16'($urandom_range(1, 65535));
         FLAW_END: begin
            do end_b = 8'($urandom_range(0, 255)); while (end_b == END_BYTE);
         end
         FLAW_CUT: keep = $urandom_range(0, len + 3);
         default: ;
      endcase
      n = put_frame(pl, flip, end_b, keep, (cur_timeout > 4) ? 4 : cur_timeout - 1);
      // a cut frame is left open; enough ticks close it with a timeout
      if (flaw == FLAW_CUT) begin
         repeat (cur_timeout) push_tick();
         n += cur_timeout;
      end
      return n;
   endfunction

   // line noise while hunting: ticks and non-start bytes, all ignored
   function automatic void gen_noise();
      logic [7:0] b;
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 2) == 0) begin
            push_tick();
         end else begin
            do b = 8'($urandom_range(0, 255)); while (b == START_BYTE);
            push_beat(KIND_BYTE, b);
         end
      end
   endfunction

   // Mostly well-formed frames; the rest broken frames and noise.
   // Noise is not counted against the target.
   function automatic void gen_random(int target);
      int made;
      int r;
      made = 0;
      while (made < target) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            gen_noise();
         end else if (r < 16) begin
            made += gen_frame(FLAW_END);
         end else if (r < 24) begin
            made += gen_frame(FLAW_CRC);
         end else if (r < 32 && cur_timeout <= CUT_TICKS_MAX) begin
            made += gen_frame(FLAW_CUT);
         end else begin
            made += gen_frame(FLAW_NONE);
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // Bus driving. Inputs move on the falling edge; handshakes are
   // sampled on the rising edge, before the DUT's flops update.
   // ---------------------------------------------------------------

   // entered and left on a falling edge; valid is left high on exit
   task automatic send_beat(req_item_type it);
      req_valid   <= 1'b1;
      req_kind    <= it.kind;
      req_rx_byte <= it.data;
      do @(posedge clock); while (req_stall);
      sb.note_beat(it.kind, it.data);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Bursts of random length. Valid is only dropped when a gap follows,
   // so back-to-back bursts never lower and raise it in one step.
   // Now and then the sender holds off until all results are back.
   task automatic play_stimulus();
      int burst;
      int gap;
      while (stim_q.size() != 0) begin
         burst = $urandom_range(1, 48);
         while (burst != 0 && stim_q.size() != 0) begin
            send_beat(stim_q.pop_front());
            burst--;
         end
         if ($urandom_range(0, 39) == 0) begin
            req_valid <= 1'b0;
            wait_drained();
         end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   // only called with the core idle; the predictor follows along
   task automatic write_timeout(logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.timeout_ticks = value;
      cur_timeout      = int'(value);
   endtask

   // result side: stall pattern is picked anew for each random span, with
   // stretches of no stalls at all
   initial begin
      int mode;
      int span;
      forever begin
         mode = $urandom_range(STALL_NEVER, STALL_HEAVY);
         span = $urandom_range(16, 160);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               STALL_NEVER:  rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 99) < 25);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
               default:      rsp_stall <= ($urandom_range(0, 99) < 75);
            endcase
         end
      end
   end

   // every accepted result beat goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_rsp({rsp_event_res, rsp_payload_byte, rsp_byte_index,
                       rsp_payload_length, rsp_received_crc, rsp_computed_crc});
      end
   end

   initial begin
      logic [7:0]  pl[$];
      logic [15:0] phase_timeout[5];
      sb = new();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed part, timeout at its reset value of 100.
      // Hunting: a non-start byte, a tick carrying 0x02, a zero byte.
      push_beat(KIND_BYTE, 8'hFF);
      push_beat(KIND_TICK, START_BYTE);
      push_beat(KIND_BYTE, 8'h00);
      // empty payload, good: both CRCs stay zero
      void'(put_frame(pl, 16'h0000, END_BYTE, 4, 0));
      // one all-ones payload byte, good
      pl.push_back(8'hFF);
      void'(put_frame(pl, 16'h0000, END_BYTE, 5, 0));
      // start byte as payload data, bad CRC
      pl.delete();
      pl.push_back(START_BYTE);
      pl.push_back(8'h00);
      void'(put_frame(pl, 16'h8000, END_BYTE, 6, 0));
      // bad end byte wins over a CRC mismatch; CRC field all ones
      pl.delete();
      void'(put_frame(pl, 16'hFFFF, 8'hFF, 4, 0));

      gen_random(PHASE_ITEMS);
      play_stimulus();
      wait_drained();

      // timeout sweep: minimum, maximum, two random, back to default
      phase_timeout[0] = 16'd1;
      phase_timeout[1] = TICKS_MAX;
      phase_timeout[2] = 16'($urandom_range(2, 40));
      phase_timeout[3] = 16'($urandom_range(41, CUT_TICKS_MAX));
      phase_timeout[4] = TIMEOUT_RESET;
      foreach (phase_timeout[p]) begin
         write_timeout(phase_timeout[p]);
         if (cur_timeout == int'(TICKS_MAX)) begin
            // full-length payload of 255 bytes, so the byte index runs up to 254
            pl.delete();
            repeat (255) pl.push_back(8'($urandom_range(0, 255)));
            void'(put_frame(pl, 16'h0000, END_BYTE, 259, 4));
         end
         gen_random(PHASE_ITEMS);
         play_stimulus();
         wait_drained();
      end

      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hang guard
   initial begin
      #LIMIT_NS;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/cpd_pkg.sv
src/cpd_rsp_queue.sv
src/crc16_packet_deframer_core.sv
src/cpd_checker.sv
sim/crc16_packet_deframer_core_tb.sv
